// File: hw/rtl/dmxpfa_pkg.sv
// Shared types and constants for the DMX universe pixel frame assembler.
// No dependencies; used by every module under hw/rtl.
package dmxpfa_pkg;

    localparam int MAX_UNI_DEF = 16;
    localparam int CH_PER_UNI  = 512;
    localparam int POS_IN_W    = 9;    // log2 of channels per universe
    localparam int POS_W       = 10;
    localparam int PC_W        = 12;
    localparam int UNI_W       = 15;
    localparam int CLEN_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_NBYTES  = 5;
    localparam int NUM_LIGHTS  = 4;

    // linear channel index: universe (up to 64) times 512 plus position
    localparam int LIN_W       = 15;

    // divide by three through a reciprocal; exact for any LIN_W-bit value
    localparam int RCP_SH                = LIN_W + 2;
    localparam logic [RCP_SH-1:0] DIV3_RCP = RCP_SH'((2 ** RCP_SH + 2) / 3);

    typedef enum logic [2:0] {
        EV_PIXEL   = 3'd0,
        EV_CFG_OK  = 3'd1,
        EV_CFG_LEN = 3'd2,
        EV_CFG_SUM = 3'd3,
        EV_FRAME   = 3'd4
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_COUNT     = 2'd0,
        CFG_CONFIG_UNIVERSE = 2'd1,
        CFG_CONFIG_LENGTH   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_END  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_event                      ev;
        logic [LIN_W-1:0]            lin;
        logic [7:0]                  value;
        logic [NUM_LIGHTS-1:0][7:0]  lights;
    } t_entry;

endpackage

// File: hw/rtl/dmxpfa_front.sv
// Front end: configuration registers, packet tracking and classification of each beat.
// Depends on dmxpfa_pkg; pushes one t_entry per result into dmxpfa_queue.
module dmxpfa_front #(
    parameter int MAX_UNIVERSES = dmxpfa_pkg::MAX_UNI_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [dmxpfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dmxpfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [dmxpfa_pkg::UNI_W-1:0]       i_universe,
    input  logic [7:0]                         i_channel_byte,
    input  logic                               i_q_ready,
    output logic                               o_push,
    output dmxpfa_pkg::t_entry                 o_entry
);

    localparam int UIDX_W = (MAX_UNIVERSES > 1) ? $clog2(MAX_UNIVERSES) : 1;
    localparam int CNT_W  = $clog2(MAX_UNIVERSES + 1);
    localparam int LIN_W  = dmxpfa_pkg::LIN_W;
    localparam int POS_W  = dmxpfa_pkg::POS_W;
    localparam int PIN_W  = dmxpfa_pkg::POS_IN_W;

    logic [dmxpfa_pkg::PC_W-1:0]   r_pixel_count;
    logic [dmxpfa_pkg::UNI_W-1:0]  r_cfg_uni;
    logic [dmxpfa_pkg::CLEN_W-1:0] r_cfg_len;
    logic [POS_W-1:0]              r_pos;
    logic [7:0]                    r_cfg_b [dmxpfa_pkg::CFG_NBYTES];
    logic [MAX_UNIVERSES-1:0]      r_seen;
    logic [CNT_W-1:0]              r_seen_cnt;

    logic [13:0]       w_pc3;
    logic [14:0]       w_tot_sum;
    logic [5:0]        w_tot_raw;
    logic [CNT_W-1:0]  w_total;
    logic              w_is_cfg;
    logic              w_in_frame;
    logic [LIN_W-1:0]  w_lin;
    logic              w_pix_ok;
    logic [9:0]        w_sum;
    logic [UIDX_W-1:0] w_idx;
    logic [CNT_W-1:0]  w_cnt_nx;
    logic              w_frame_done;
    logic              w_accept;
    logic              w_push;

    assign o_in_ready = i_q_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_pc3     = {2'b00, r_pixel_count} + {1'b0, r_pixel_count, 1'b0};
        w_tot_sum = {1'b0, w_pc3} + 15'd511;
        w_tot_raw = w_tot_sum[14:9];
        if ({10'd0, w_tot_raw} > 16'(MAX_UNIVERSES)) begin
            w_total = CNT_W'(MAX_UNIVERSES);
        end else begin
            w_total = CNT_W'(w_tot_raw);
        end
        w_is_cfg   = (i_universe == r_cfg_uni);
        w_in_frame = (i_universe < dmxpfa_pkg::UNI_W'(w_total));
        w_lin      = {i_universe[LIN_W-PIN_W-1:0], r_pos[PIN_W-1:0]};
        w_pix_ok   = (r_pos < POS_W'(dmxpfa_pkg::CH_PER_UNI))
                     && ({1'b0, w_lin} < 16'(w_pc3));
        w_sum      = {2'b00, r_cfg_b[0]} + {2'b00, r_cfg_b[1]}
                     + {2'b00, r_cfg_b[2]} + {2'b00, r_cfg_b[3]};
        w_idx      = i_universe[UIDX_W-1:0];
        w_cnt_nx   = r_seen_cnt + CNT_W'(!r_seen[w_idx]);
        w_frame_done = w_in_frame && (w_cnt_nx == w_total);
    end

    always_comb begin
        w_push         = 1'b0;
        o_entry.ev     = dmxpfa_pkg::EV_PIXEL;
        o_entry.lin    = '0;
        o_entry.value  = '0;
        o_entry.lights = '0;
        if (i_command == dmxpfa_pkg::CMD_BYTE) begin
            if (!w_is_cfg && w_in_frame && w_pix_ok) begin
                w_push        = 1'b1;
                o_entry.lin   = w_lin;
                o_entry.value = i_channel_byte;
            end
        end else if (w_is_cfg) begin
            w_push = 1'b1;
            if (r_pos != r_cfg_len) begin
                o_entry.ev = dmxpfa_pkg::EV_CFG_LEN;
            end else if (w_sum != {2'b00, r_cfg_b[4]}) begin
                o_entry.ev = dmxpfa_pkg::EV_CFG_SUM;
            end else begin
                o_entry.ev     = dmxpfa_pkg::EV_CFG_OK;
                o_entry.lights = {r_cfg_b[3], r_cfg_b[2], r_cfg_b[1], r_cfg_b[0]};
            end
        end else if (w_frame_done) begin
            w_push     = 1'b1;
            o_entry.ev = dmxpfa_pkg::EV_FRAME;
        end
    end

    assign o_push = w_accept && w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= dmxpfa_pkg::PC_W'(170);
            r_cfg_uni     <= '1;
            r_cfg_len     <= dmxpfa_pkg::CLEN_W'(5);
            r_pos         <= '0;
            r_seen        <= '0;
            r_seen_cnt    <= '0;
            for (int k = 0; k < dmxpfa_pkg::CFG_NBYTES; k++) begin
                r_cfg_b[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    dmxpfa_pkg::CFG_PIXEL_COUNT: begin
                        r_pixel_count <= i_cfg_data[dmxpfa_pkg::PC_W-1:0];
                    end
                    dmxpfa_pkg::CFG_CONFIG_UNIVERSE: begin
                        r_cfg_uni <= i_cfg_data[dmxpfa_pkg::UNI_W-1:0];
                    end
                    dmxpfa_pkg::CFG_CONFIG_LENGTH: begin
                        r_cfg_len <= i_cfg_data[dmxpfa_pkg::CLEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                if (i_command == dmxpfa_pkg::CMD_BYTE) begin
                    if (w_is_cfg && (r_pos < POS_W'(dmxpfa_pkg::CFG_NBYTES))) begin
                        r_cfg_b[r_pos[2:0]] <= i_channel_byte;
                    end
                    if (r_pos != '1) begin
                        r_pos <= r_pos + POS_W'(1);
                    end
                end else begin
                    r_pos <= '0;
                    for (int k = 0; k < dmxpfa_pkg::CFG_NBYTES; k++) begin
                        r_cfg_b[k] <= '0;
                    end
                    if (!w_is_cfg && w_in_frame) begin
                        if (w_frame_done) begin
                            r_seen     <= '0;
                            r_seen_cnt <= '0;
                        end else begin
                            r_seen[w_idx] <= 1'b1;
                            r_seen_cnt    <= w_cnt_nx;
                        end
                    end
                end
            end
        end
    end

endmodule

// File: hw/rtl/dmxpfa_queue.sv
// Two-entry queue (head plus spare) between front and back end.
// Depends on dmxpfa_pkg for t_entry.
module dmxpfa_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dmxpfa_pkg::t_entry i_entry,
    output logic               o_ready,
    input  logic               i_pop,
    output logic               o_valid,
    output dmxpfa_pkg::t_entry o_entry
);

    dmxpfa_pkg::t_entry r_head;
    dmxpfa_pkg::t_entry r_tail;
    logic               r_head_v;
    logic               r_tail_v;
    logic               w_pop;

    assign o_ready = !r_tail_v;
    assign o_valid = r_head_v;
    assign o_entry = r_head;
    assign w_pop   = i_pop && r_head_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_tail_v <= 1'b0;
        end else if (w_pop) begin
            if (r_tail_v) begin
                r_tail_v <= 1'b0;
            end else begin
                r_head_v <= i_push;
            end
        end else if (i_push) begin
            if (!r_head_v) begin
                r_head_v <= 1'b1;
            end else begin
                r_tail_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_head <= r_tail_v ? r_tail : i_entry;
        end else if (i_push) begin
            if (!r_head_v) begin
                r_head <= i_entry;
            end else begin
                r_tail <= i_entry;
            end
        end
    end

endmodule

// File: hw/rtl/dmxpfa_back.sv
// Back end: turns a queued entry into pixel index and colour slot, holds the result beat.
// Depends on dmxpfa_pkg for t_entry and the divide-by-three reciprocal.
module dmxpfa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  dmxpfa_pkg::t_entry i_entry,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_event_res,
    output logic [11:0]        o_pixel_index,
    output logic [1:0]         o_color_slot,
    output logic [7:0]         o_pixel_value,
    output logic [7:0]         o_lights_out0,
    output logic [7:0]         o_lights_out1,
    output logic [7:0]         o_lights_out2,
    output logic [7:0]         o_lights_out3
);

    localparam int LIN_W = dmxpfa_pkg::LIN_W;
    localparam int SH    = dmxpfa_pkg::RCP_SH;

    logic                   r_valid;
    logic [2:0]             r_event;
    logic [11:0]            r_pix;
    logic [1:0]             r_slot;
    logic [7:0]             r_value;
    logic [3:0][7:0]        r_lights;

    logic [LIN_W+SH-1:0]    w_prod;
    logic [LIN_W-1:0]       w_pix;
    logic [LIN_W-1:0]       w_rem;

    always_comb begin
        w_prod = (LIN_W + SH)'(i_entry.lin) * (LIN_W + SH)'(dmxpfa_pkg::DIV3_RCP);
        w_pix  = w_prod[SH +: LIN_W];
        w_rem  = i_entry.lin - {w_pix[LIN_W-2:0], 1'b0} - w_pix;
    end

    assign o_pop = i_valid && (!r_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_event  <= i_entry.ev;
            r_pix    <= w_pix[11:0];
            r_slot   <= w_rem[1:0];
            r_value  <= i_entry.value;
            r_lights <= i_entry.lights;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_event_res   = r_event;
    assign o_pixel_index = r_pix;
    assign o_color_slot  = r_slot;
    assign o_pixel_value = r_value;
    assign o_lights_out0 = r_lights[0];
    assign o_lights_out1 = r_lights[1];
    assign o_lights_out2 = r_lights[2];
    assign o_lights_out3 = r_lights[3];

endmodule

// File: hw/rtl/dmx_universe_pixel_frame_assembler_top.sv
// Top level of the DMX universe pixel frame assembler: front, queue and back end.
// Depends on dmxpfa_pkg, dmxpfa_front, dmxpfa_queue, dmxpfa_back.
//
//  channel | handshake                 | beat contents
//  --------+---------------------------+------------------------------------------
//  cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//  in      | i_in_valid / o_in_ready   | i_command, i_universe, i_channel_byte
//  out     | o_out_valid / i_out_ready | o_event_res, pixel index/slot/value, lights
//
// One input beat per cycle while the queue has room; the front end classifies each
// beat combinationally, the back end does one divide-by-three multiply per result
// taken, and the two-entry queue ahead of the result register absorbs a stall.
// Synchronous active-low reset clears packet state, universe marks and the queue.
// Config port is always ready.
module dmx_universe_pixel_frame_assembler_top #(
    parameter int MAX_UNIVERSES = dmxpfa_pkg::MAX_UNI_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dmxpfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dmxpfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [dmxpfa_pkg::UNI_W-1:0]       i_universe,
    input  logic [7:0]                         i_channel_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [2:0]                         o_event_res,
    output logic [11:0]                        o_pixel_index,
    output logic [1:0]                         o_color_slot,
    output logic [7:0]                         o_pixel_value,
    output logic [7:0]                         o_lights_out0,
    output logic [7:0]                         o_lights_out1,
    output logic [7:0]                         o_lights_out2,
    output logic [7:0]                         o_lights_out3
);

    logic               w_push;
    logic               w_q_ready;
    logic               w_q_valid;
    logic               w_pop;
    dmxpfa_pkg::t_entry w_push_entry;
    dmxpfa_pkg::t_entry w_head_entry;

    assign o_cfg_ready = 1'b1;

    dmxpfa_front #(
        .MAX_UNIVERSES (MAX_UNIVERSES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_universe     (i_universe),
        .i_channel_byte (i_channel_byte),
        .i_q_ready      (w_q_ready),
        .o_push         (w_push),
        .o_entry        (w_push_entry)
    );

    dmxpfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_head_entry)
    );

    dmxpfa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_entry       (w_head_entry),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_res   (o_event_res),
        .o_pixel_index (o_pixel_index),
        .o_color_slot  (o_color_slot),
        .o_pixel_value (o_pixel_value),
        .o_lights_out0 (o_lights_out0),
        .o_lights_out1 (o_lights_out1),
        .o_lights_out2 (o_lights_out2),
        .o_lights_out3 (o_lights_out3)
    );

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == dmxpfa_pkg::EV_PIXEL) |-> (o_color_slot != 2'd3))
        else $error("colour slot out of range");

    a_lights_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res != dmxpfa_pkg::EV_CFG_OK)
        |-> (o_lights_out0 == 8'd0) && (o_lights_out1 == 8'd0)
            && (o_lights_out2 == 8'd0) && (o_lights_out3 == 8'd0))
        else $error("lights set on a non-config result");

    a_pixel_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res != dmxpfa_pkg::EV_PIXEL)
        |-> (o_pixel_index == 12'd0) && (o_color_slot == 2'd0) && (o_pixel_value == 8'd0))
        else $error("pixel fields set on a non-pixel result");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_q_ready)
        else $error("queue pushed while full");

endmodule

// File: tb/dmxpfa_frame_checker.sv
`timescale 1ns / 1ps
// Result checker for the DMX universe pixel frame assembler: follows config writes and
// input beats, predicts pixel writes, config verdicts and frame completion, compares results.
// Depends on dmxpfa_pkg.
module dmxpfa_frame_checker
    import dmxpfa_pkg::*;
#(
    parameter int MAX_UNIVERSES = MAX_UNI_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_command,
    input  logic [UNI_W-1:0]      i_universe,
    input  logic [7:0]            i_channel_byte,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [2:0]            i_event_res,
    input  logic [11:0]           i_pixel_index,
    input  logic [1:0]            i_color_slot,
    input  logic [7:0]            i_pixel_value,
    input  logic [7:0]            i_lights_out0,
    input  logic [7:0]            i_lights_out1,
    input  logic [7:0]            i_lights_out2,
    input  logic [7:0]            i_lights_out3,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int POS_LIMIT  = 2 ** POS_W - 1;

    typedef struct packed {
        t_event                     ev;
        logic [PC_W-1:0]            pixel;
        logic [1:0]                 slot;
        logic [7:0]                 value;
        logic [NUM_LIGHTS-1:0][7:0] lights;
    } t_pixel_event;

    logic [PC_W-1:0]          pixel_count_q;
    logic [UNI_W-1:0]         cfg_universe_q;
    logic [CLEN_W-1:0]        cfg_length_q;
    logic [POS_W-1:0]         byte_pos;
    logic [7:0]               cfg_bytes [CFG_NBYTES];
    logic [MAX_UNIVERSES-1:0] uni_marks;
    int                       marks_set;
    t_pixel_event             due_events [$];
    t_pixel_event             want;

    function automatic int universes_in_frame();
        int n;
        n = (int'(pixel_count_q) * 3 + CH_PER_UNI - 1) / CH_PER_UNI;
        return (n > MAX_UNIVERSES) ? MAX_UNIVERSES : n;
    endfunction

    task automatic assemble_beat(input t_cmd cmd, input logic [UNI_W-1:0] uni,
                                 input logic [7:0] val);
        t_pixel_event ev_q;
        int total;
        int lin;
        int sum;
        total = universes_in_frame();
        ev_q = '0;
        if (cmd == CMD_BYTE) begin
            if (uni == cfg_universe_q) begin
                if (byte_pos < CFG_NBYTES)
                    cfg_bytes[byte_pos] = val;
            end else if (int'(uni) < total && byte_pos < CH_PER_UNI) begin
                lin = int'(uni) * CH_PER_UNI + int'(byte_pos);
                if (lin / 3 < int'(pixel_count_q)) begin
                    ev_q.ev    = EV_PIXEL;
                    ev_q.pixel = PC_W'(lin / 3);
                    ev_q.slot  = 2'(lin % 3);
                    ev_q.value = val;
                    due_events.push_back(ev_q);
                end
            end
            if (byte_pos < POS_LIMIT)
                byte_pos++;
        end else begin
            if (uni == cfg_universe_q) begin
                sum = int'(cfg_bytes[0]) + int'(cfg_bytes[1]) + int'(cfg_bytes[2])
                    + int'(cfg_bytes[3]);
                if (byte_pos != cfg_length_q) begin
                    ev_q.ev = EV_CFG_LEN;
                end else if (sum != int'(cfg_bytes[4])) begin
                    ev_q.ev = EV_CFG_SUM;
                end else begin
                    ev_q.ev = EV_CFG_OK;
                    for (int k = 0; k < NUM_LIGHTS; k++)
                        ev_q.lights[k] = cfg_bytes[k];
                end
                due_events.push_back(ev_q);
            end else if (int'(uni) < total) begin
                if (!uni_marks[uni]) begin
                    uni_marks[uni] = 1'b1;
                    marks_set++;
                end
                if (marks_set == total) begin
                    ev_q.ev = EV_FRAME;
                    due_events.push_back(ev_q);
                    uni_marks = '0;
                    marks_set = 0;
                end
            end
            byte_pos = '0;
            foreach (cfg_bytes[k])
                cfg_bytes[k] = '0;
        end
    endtask

    task automatic check_field(input string fname, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, fname, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pixel_count_q  = PC_W'(170);
            cfg_universe_q = '1;
            cfg_length_q   = CLEN_W'(5);
            byte_pos       = '0;
            foreach (cfg_bytes[k])
                cfg_bytes[k] = '0;
            uni_marks      = '0;
            marks_set      = 0;
            due_events.delete();
            o_fail_count   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PIXEL_COUNT:     pixel_count_q  = i_cfg_data[PC_W-1:0];
                    CFG_CONFIG_UNIVERSE: cfg_universe_q = i_cfg_data[UNI_W-1:0];
                    CFG_CONFIG_LENGTH:   cfg_length_q   = i_cfg_data[CLEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                assemble_beat(t_cmd'(i_command), i_universe, i_channel_byte);
            if (i_out_valid && i_out_ready) begin
                if (due_events.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual event %0d",
                             $time, i_event_res);
                    o_fail_count++;
                end else begin
                    want = due_events.pop_front();
                    check_field("event_res",   int'(want.ev),        int'(i_event_res));
                    check_field("pixel_index", int'(want.pixel),     int'(i_pixel_index));
                    check_field("color_slot",  int'(want.slot),      int'(i_color_slot));
                    check_field("pixel_value", int'(want.value),     int'(i_pixel_value));
                    check_field("lights_out0", int'(want.lights[0]), int'(i_lights_out0));
                    check_field("lights_out1", int'(want.lights[1]), int'(i_lights_out1));
                    check_field("lights_out2", int'(want.lights[2]), int'(i_lights_out2));
                    check_field("lights_out3", int'(want.lights[3]), int'(i_lights_out3));
                end
            end
        end
        o_pending = due_events.size();
    end

endmodule

// File: tb/dmx_universe_pixel_frame_assembler_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the DMX universe pixel frame assembler: drives config writes, DMX
// packets and result back-pressure; checking is left to dmxpfa_frame_checker.
// Depends on dmxpfa_pkg, dmxpfa_frame_checker and dmx_universe_pixel_frame_assembler_top.
module dmx_universe_pixel_frame_assembler_top_tb;
    import dmxpfa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 8;
    localparam int PHASE_BEATS = 16;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_command;
    logic [UNI_W-1:0]      i_universe;
    logic [7:0]            i_channel_byte;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [2:0]            o_event_res;
    logic [11:0]           o_pixel_index;
    logic [1:0]            o_color_slot;
    logic [7:0]            o_pixel_value;
    logic [7:0]            o_lights_out0;
    logic [7:0]            o_lights_out1;
    logic [7:0]            o_lights_out2;
    logic [7:0]            o_lights_out3;

    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    int               beats_sent  = 0;
    int               hold_req    = 0;
    int               hold_done   = 0;
    int               tx_run_left = 0;
    bit               tx_busy;
    int               rx_run_left = 0;
    bit               rx_busy;
    logic [UNI_W-1:0] cfg_uni_tb;
    int               frame_unis;
    bit               long_cfg_sent;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    dmx_universe_pixel_frame_assembler_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_universe     (i_universe),
        .i_channel_byte (i_channel_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_pixel_index  (o_pixel_index),
        .o_color_slot   (o_color_slot),
        .o_pixel_value  (o_pixel_value),
        .o_lights_out0  (o_lights_out0),
        .o_lights_out1  (o_lights_out1),
        .o_lights_out2  (o_lights_out2),
        .o_lights_out3  (o_lights_out3)
    );

    dmxpfa_frame_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_universe     (i_universe),
        .i_channel_byte (i_channel_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_event_res    (o_event_res),
        .i_pixel_index  (o_pixel_index),
        .i_color_slot   (o_color_slot),
        .i_pixel_value  (o_pixel_value),
        .i_lights_out0  (o_lights_out0),
        .i_lights_out1  (o_lights_out1),
        .i_lights_out2  (o_lights_out2),
        .i_lights_out3  (o_lights_out3),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result sink: random stall per beat, plus a long hold-off on request
    initial begin : result_sink
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_done != hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_done++;
            end
            if (rx_run_left == 0) begin
                rx_run_left = $urandom_range(1, 40);
                rx_busy     = ($urandom_range(0, 3) != 0);
            end
            rx_run_left--;
            gap = rx_busy ? $urandom_range(0, 11) : 0;
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_beat(input t_cmd cmd, input logic [UNI_W-1:0] uni,
                             input logic [7:0] data);
        int gap;
        if (tx_run_left == 0) begin
            tx_run_left = $urandom_range(1, 40);
            tx_busy     = ($urandom_range(0, 3) != 0);
        end
        tx_run_left--;
        gap = tx_busy ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_universe     <= uni;
        i_channel_byte <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // unused high bits of the write data are randomised; the block keeps only the field width
    task automatic write_regs(input logic [PC_W-1:0] pc, input logic [UNI_W-1:0] cu,
                              input logic [CLEN_W-1:0] cl);
        logic [CFG_DATA_W-1:0] data [3];
        t_cfg_idx              idx [3];
        int                    n;
        data[0] = {4'($urandom), pc};
        data[1] = {1'($urandom), cu};
        data[2] = {6'($urandom), cl};
        idx[0]  = CFG_PIXEL_COUNT;
        idx[1]  = CFG_CONFIG_UNIVERSE;
        idx[2]  = CFG_CONFIG_LENGTH;
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= data[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cfg_uni_tb = cu;
        n = (int'(pc) * 3 + CH_PER_UNI - 1) / CH_PER_UNI;
        frame_unis = (n > MAX_UNI_DEF) ? MAX_UNI_DEF : n;
    endtask

    function automatic logic [UNI_W-1:0] in_frame_universe();
        if (frame_unis > 0)
            return UNI_W'($urandom_range(0, frame_unis - 1));
        return UNI_W'($urandom);
    endfunction

    task automatic send_pixel_packet(input logic [UNI_W-1:0] uni, input int len);
        for (int k = 0; k < len; k++)
            send_beat(CMD_BYTE, uni, 8'($urandom));
        send_beat(CMD_END, uni, 8'($urandom));
    endtask

    task automatic send_config_packet(input int len, input bit good);
        logic [7:0] cb [CFG_NBYTES];
        foreach (cb[k])
            cb[k] = 8'($urandom);
        if (good) begin
            if (len < CFG_NBYTES) begin
                foreach (cb[k])
                    cb[k] = '0;
            end else begin
                for (int k = 0; k < NUM_LIGHTS; k++)
                    cb[k] = 8'($urandom_range(0, 63));
                cb[4] = cb[0] + cb[1] + cb[2] + cb[3];
            end
        end
        for (int k = 0; k < len; k++)
            send_beat(CMD_BYTE, cfg_uni_tb, (k < CFG_NBYTES) ? cb[k] : 8'($urandom));
        send_beat(CMD_END, cfg_uni_tb, 8'($urandom));
    endtask

    // universe hops mid-packet between pixel, config and stray universes
    task automatic send_broken_packet();
        int len;
        logic [UNI_W-1:0] uni [3];
        len = $urandom_range(1, 8);
        for (int k = 0; k <= len; k++) begin
            uni[0] = in_frame_universe();
            uni[1] = cfg_uni_tb;
            uni[2] = UNI_W'($urandom);
            send_beat((k == len) ? CMD_END : CMD_BYTE, uni[$urandom_range(0, 2)],
                      8'($urandom));
        end
    endtask

    task automatic run_phase(input logic [PC_W-1:0] pc, input logic [UNI_W-1:0] cu,
                             input logic [CLEN_W-1:0] cl, input int long_len, input bit hold);
        int stop_at;
        int roll;
        int len;
        write_regs(pc, cu, cl);
        long_cfg_sent = (cl != CLEN_W'(CH_PER_UNI));
        stop_at = beats_sent + PHASE_BEATS;
        if (hold)
            hold_req++;
        if (long_len > 0)
            send_pixel_packet(in_frame_universe(), long_len);
        while (beats_sent < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
                send_pixel_packet(in_frame_universe(), len);
            end else if (roll < 70) begin
                if (cl > 40 && long_cfg_sent)
                    len = $urandom_range(0, 12);
                else if ($urandom_range(0, 9) < 7)
                    len = int'(cl);
                else
                    len = $urandom_range(0, int'(cl) + 3);
                if (len > 40)
                    long_cfg_sent = 1'b1;
                send_config_packet(len, 1'($urandom));
            end else if (roll < 80) begin
                send_pixel_packet(UNI_W'($urandom_range(frame_unis, 2 ** UNI_W - 1)),
                                  $urandom_range(0, 6));
            end else if (roll < 90) begin
                send_broken_packet();
            end else begin
                send_beat(CMD_END, UNI_W'($urandom), 8'($urandom));
            end
        end
        drain_results();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_command      = CMD_BYTE;
        i_universe     = '0;
        i_channel_byte = '0;
        cfg_uni_tb     = '1;
        frame_unis     = 1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset config: one pixel universe, config on the top universe, length 5
        send_beat(CMD_BYTE, 15'd0, 8'h00);
        send_beat(CMD_BYTE, 15'd0, 8'hFF);
        send_beat(CMD_BYTE, 15'd0, 8'h5A);
        send_beat(CMD_END,  15'd0, 8'hFF);
        send_beat(CMD_BYTE, '1, 8'h01);
        send_beat(CMD_BYTE, '1, 8'h02);
        send_beat(CMD_BYTE, '1, 8'h03);
        send_beat(CMD_BYTE, '1, 8'h04);
        send_beat(CMD_BYTE, '1, 8'h0A);
        send_beat(CMD_END,  '1, 8'h00);
        // checksum sum overflows a byte
        send_beat(CMD_BYTE, '1, 8'hFF);
        send_beat(CMD_BYTE, '1, 8'hFF);
        send_beat(CMD_BYTE, '1, 8'hFF);
        send_beat(CMD_BYTE, '1, 8'hFF);
        send_beat(CMD_BYTE, '1, 8'hFC);
        send_beat(CMD_END,  '1, 8'h00);
        send_beat(CMD_BYTE, '1, 8'h11);
        send_beat(CMD_BYTE, '1, 8'h22);
        send_beat(CMD_END,  '1, 8'h00);
        send_beat(CMD_BYTE, 15'd1, 8'h77);
        send_beat(CMD_END,  15'd1, 8'h00);
        send_beat(CMD_END,  15'd0, 8'h00);
        drain_results();

        run_phase(12'd2730, 15'd5, 10'd5, 1030, 1'b1);
        run_phase(12'd1, 15'd0, 10'd512, 0, 1'b0);
        run_phase(12'd0, 15'd32767, 10'd3, 0, 1'b0);
        run_phase(12'd4095, 15'd16, 10'd4, 0, 1'b1);
        run_phase(12'd171, 15'd2, 10'd480, 0, 1'b0);
        repeat (3)
            run_phase(12'($urandom_range(1, 2730)), 15'($urandom),
                      10'($urandom_range(5, 40)), 0, 1'b0);
        run_phase(12'($urandom_range(1, 700)), 15'($urandom_range(0, 4)), 10'd5, 0, 1'b1);
        run_phase(12'd170, 15'd32767, 10'd5, 0, 1'b0);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dmxpfa_pkg.sv
hw/rtl/dmxpfa_front.sv
hw/rtl/dmxpfa_queue.sv
hw/rtl/dmxpfa_back.sv
hw/rtl/dmx_universe_pixel_frame_assembler_top.sv
tb/dmxpfa_frame_checker.sv
tb/dmx_universe_pixel_frame_assembler_top_tb.sv
